// File: hdl/ftd_pkg.sv
// ============================================================================
// ftd_pkg
// shared constants for the frequency to timer divider
// ============================================================================
package ftd_pkg;

    localparam int unsigned CLOCK_HZ_DEF = 32'd16000000;

    localparam int FREQ_W    = 30;
    localparam int UNIT_W    = 2;
    localparam int CODE_W    = 3;
    localparam int CMP_W     = 16;
    localparam int DIV_W     = 17;   // final divider, up to DIV_LIMIT
    localparam int DEN2_W    = 27;   // divider times prescaler, up to 2^26
    localparam int SIDE2_W   = CODE_W + CMP_W + 1;

    localparam logic [DIV_W-1:0]  DIV_LIMIT  = 17'h10000;
    localparam logic [FREQ_W-1:0] ACTUAL_MAX = 30'h3FFFFFFF;

    localparam logic [UNIT_W-1:0] UNIT_MHZ_MILLI = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_HZ        = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_KHZ       = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_MHZ       = 2'd3;

    localparam logic [CODE_W-1:0] PRE_DIV1    = 3'd1;
    localparam logic [CODE_W-1:0] PRE_DIV8    = 3'd2;
    localparam logic [CODE_W-1:0] PRE_DIV64   = 3'd3;
    localparam logic [CODE_W-1:0] PRE_DIV256  = 3'd4;
    localparam logic [CODE_W-1:0] PRE_DIV1024 = 3'd5;

endpackage

// File: hdl/ftd_if.sv
// ============================================================================
// ftd_req_if / ftd_rsp_if
// request and response channels with valid/ready handshake
// ============================================================================
interface ftd_req_if;
    logic                      valid;
    logic                      ready;
    logic [ftd_pkg::FREQ_W-1:0] freq_value;
    logic [ftd_pkg::UNIT_W-1:0] unit_index;

    modport source (output valid, output freq_value, output unit_index, input ready);
    modport sink   (input valid, input freq_value, input unit_index, output ready);
endinterface

interface ftd_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [ftd_pkg::CODE_W-1:0] prescaler_code;
    logic [ftd_pkg::CMP_W-1:0]  compare_value;
    logic                      too_high;
    logic [ftd_pkg::FREQ_W-1:0] actual_freq;

    modport source (output valid, output prescaler_code, output compare_value,
                    output too_high, output actual_freq, input ready);
    modport sink   (input valid, input prescaler_code, input compare_value,
                    input too_high, input actual_freq, output ready);
endinterface

// File: hdl/ftd_div_pipe.sv
// ============================================================================
// ftd_div_pipe
// restoring divider, one quotient bit per register stage
// ============================================================================
module ftd_div_pipe #(
    parameter int NW = 49,
    parameter int DW = 30,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);
    logic          valid_reg [NW];
    logic [NW-1:0] num_reg   [NW];
    logic [NW-1:0] quo_reg   [NW];
    logic [DW-1:0] rem_reg   [NW];
    logic [DW-1:0] den_reg   [NW];
    logic [SW-1:0] side_reg  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] n_in;
        logic [NW-1:0] q_in;
        logic [DW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   r_ext;
        logic          ge;
        logic [DW:0]   r_sub;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign n_in = in_num;
            assign q_in = '0;
            assign r_in = '0;
            assign d_in = in_den;
            assign s_in = in_side;
        end
        else begin : g_next
            assign v_in = valid_reg[k-1];
            assign n_in = num_reg[k-1];
            assign q_in = quo_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        always_comb
        begin
            r_ext    = {r_in, n_in[NW-1]};
            ge       = (r_ext >= {1'b0, d_in});
            r_sub    = ge ? (r_ext - {1'b0, d_in}) : r_ext;
            rem_next = r_sub[DW-1:0];
            quo_next = {q_in[NW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k]  <= {n_in[NW-2:0], 1'b0};
                quo_reg[k]  <= quo_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_quo   = quo_reg[NW-1];
    assign out_side  = side_reg[NW-1];
endmodule

// File: hdl/ftd_presel.sv
// ============================================================================
// ftd_presel
// prescaler choice, divider clipping and second divisor, one register stage
// ============================================================================
module ftd_presel #(
    parameter int NW = 49
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [NW-1:0]               in_quo,
    input  logic [NW-1:0]               in_num,
    output logic                        out_valid,
    output logic [NW-1:0]               out_num,
    output logic [ftd_pkg::DEN2_W-1:0]  out_den,
    output logic [ftd_pkg::SIDE2_W-1:0] out_side
);
    import ftd_pkg::*;

    logic              valid_reg;
    logic [NW-1:0]     num_reg;
    logic [DEN2_W-1:0] den_reg;
    logic [SIDE2_W-1:0] side_reg;

    logic [NW-1:0]     lim_ext;
    logic [NW-1:0]     q8, q64, q256, q1024;
    logic [DIV_W-1:0]  div_sel;
    logic [CODE_W-1:0] code_sel;
    logic              th_sel;
    logic [DEN2_W-1:0] den_next;
    logic [CMP_W-1:0]  cmp_next;
    logic [DIV_W-1:0]  div_m1;

    always_comb
    begin
        lim_ext  = NW'(DIV_LIMIT);
        q8       = in_quo >> 3;
        q64      = in_quo >> 6;
        q256     = in_quo >> 8;
        q1024    = in_quo >> 10;
        th_sel   = 1'b0;
        code_sel = PRE_DIV1;
        den_next = '0;
        if (in_quo == '0)
        begin
            th_sel   = 1'b1;
            div_sel  = DIV_W'(1);
        end
        else if (in_quo <= lim_ext)
        begin
            div_sel  = in_quo[DIV_W-1:0];
        end
        else if (q8 <= lim_ext)
        begin
            div_sel  = q8[DIV_W-1:0];
            code_sel = PRE_DIV8;
        end
        else if (q64 <= lim_ext)
        begin
            div_sel  = q64[DIV_W-1:0];
            code_sel = PRE_DIV64;
        end
        else if (q256 <= lim_ext)
        begin
            div_sel  = q256[DIV_W-1:0];
            code_sel = PRE_DIV256;
        end
        else if (q1024 <= lim_ext)
        begin
            div_sel  = q1024[DIV_W-1:0];
            code_sel = PRE_DIV1024;
        end
        else
        begin
            div_sel  = DIV_LIMIT;
            code_sel = PRE_DIV1024;
        end

        case (code_sel)
            PRE_DIV8:    den_next = DEN2_W'(div_sel) << 3;
            PRE_DIV64:   den_next = DEN2_W'(div_sel) << 6;
            PRE_DIV256:  den_next = DEN2_W'(div_sel) << 8;
            PRE_DIV1024: den_next = DEN2_W'(div_sel) << 10;
            default:     den_next = DEN2_W'(div_sel);
        endcase

        div_m1   = div_sel - DIV_W'(1);
        cmp_next = div_m1[CMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= in_num;
            den_reg  <= den_next;
            side_reg <= {code_sel, cmp_next, th_sel};
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;
endmodule

// File: hdl/frequency_to_timer_divider_unit.sv
// ============================================================================
// frequency_to_timer_divider_unit
// timer prescaler and compare value from a requested toggle frequency
// ============================================================================
//  channel | dir | word
//  --------+-----+---------------------------------------------------------
//  req     | in  | freq_value (Q14.16), unit_index (mHz/Hz/kHz/MHz)
//  rsp     | out | prescaler_code, compare_value, too_high, actual_freq
//
//  fully pipelined: one word accepted per cycle while the pipeline is not stalled;
//  NW is the width of clock*250*2^17 (49 bits at 16 MHz) and of the quotient
//  of the two one-bit-per-stage dividers
//  a full output register with the response not taken stalls the whole
//  pipeline together; nothing is dropped or repeated
//  rst_n clears only the valid bits, payload registers are not reset
// ============================================================================
module frequency_to_timer_divider_unit #(
    parameter int unsigned CLOCK_HZ = ftd_pkg::CLOCK_HZ_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ftd_req_if.sink      req,
    ftd_rsp_if.source    rsp
);
    import ftd_pkg::*;

    // base divisor per unit, scaled by 2^17; this is also the numerator
    // of the achieved frequency, since halving and doubling cancel there
    localparam logic [63:0] BASE_CLK = 64'(CLOCK_HZ) * 64'd250;
    localparam int          NW       = $clog2(BASE_CLK + 64'd1) + 17;
    localparam logic [63:0] NUM_U0   = BASE_CLK << 17;
    localparam logic [63:0] NUM_U1   = (BASE_CLK / 64'd1000) << 17;
    localparam logic [63:0] NUM_U2   = (BASE_CLK / 64'd1000000) << 17;
    localparam logic [63:0] NUM_U3   = (BASE_CLK / 64'd1000000000) << 17;

    logic              en;
    logic [NW-1:0]     num_sel;

    // first divider: raw divider = numerator / freq
    logic              d1_valid;
    logic [NW-1:0]     d1_quo;
    logic [NW-1:0]     d1_num;

    // prescaler stage
    logic              ps_valid;
    logic [NW-1:0]     ps_num;
    logic [DEN2_W-1:0] ps_den;
    logic [SIDE2_W-1:0] ps_side;

    // second divider: achieved frequency
    logic              d2_valid;
    logic [NW-1:0]     d2_quo;
    logic [SIDE2_W-1:0] d2_side;

    logic [FREQ_W-1:0] actual_sat;

    logic              rsp_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CMP_W-1:0]  cmp_reg;
    logic              th_reg;
    logic [FREQ_W-1:0] actual_reg;

    // the whole pipe moves whenever the output register is free or drained
    assign en        = !rsp_valid_reg || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        case (req.unit_index)
            UNIT_MHZ_MILLI: num_sel = NUM_U0[NW-1:0];
            UNIT_HZ:        num_sel = NUM_U1[NW-1:0];
            UNIT_KHZ:       num_sel = NUM_U2[NW-1:0];
            UNIT_MHZ:       num_sel = NUM_U3[NW-1:0];
            default:        num_sel = NUM_U0[NW-1:0];
        endcase
    end

    // a zero frequency divides to all ones, which the prescaler stage clips
    ftd_div_pipe #(
        .NW (NW),
        .DW (FREQ_W),
        .SW (NW)
    ) u_div_raw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .in_num    (num_sel),
        .in_den    (req.freq_value),
        .in_side   (num_sel),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (d1_num)
    );

    ftd_presel #(
        .NW (NW)
    ) u_presel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .in_quo    (d1_quo),
        .in_num    (d1_num),
        .out_valid (ps_valid),
        .out_num   (ps_num),
        .out_den   (ps_den),
        .out_side  (ps_side)
    );

    ftd_div_pipe #(
        .NW (NW),
        .DW (DEN2_W),
        .SW (SIDE2_W)
    ) u_div_act (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ps_valid),
        .in_num    (ps_num),
        .in_den    (ps_den),
        .in_side   (ps_side),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_side  (d2_side)
    );

    // saturate the achieved frequency to the Q14.16 range
    assign actual_sat = (d2_quo > NW'(ACTUAL_MAX)) ? ACTUAL_MAX : d2_quo[FREQ_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg   <= d2_side[SIDE2_W-1 -: CODE_W];
            cmp_reg    <= d2_side[CMP_W:1];
            th_reg     <= d2_side[0];
            actual_reg <= actual_sat;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.prescaler_code = code_reg;
    assign rsp.compare_value  = cmp_reg;
    assign rsp.too_high       = th_reg;
    assign rsp.actual_freq    = actual_reg;
endmodule

// File: tb/frequency_to_timer_divider_unit_tb.sv
// ============================================================================
// frequency_to_timer_divider_unit_tb
// self-checking bench for the frequency to timer divider, predicts every
// response word in a scoreboard and compares it field by field
// ============================================================================
module frequency_to_timer_divider_unit_tb;
    import ftd_pkg::*;

    localparam longint unsigned CLK_HZ = 64'd16000000;
    localparam int LATENCY = 100;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CMP_W-1:0]  cmp;
        logic              high;
        logic [FREQ_W-1:0] actual;
    } divider_word_t;

    // scoreboard: predicts the timer setting for each accepted request
    class divider_scoreboard;
        divider_word_t pending[$];
        int mismatches = 0;
        int checked = 0;
        int too_high_seen = 0;
        int code_seen[8];

        function automatic longint unsigned unit_base(logic [UNIT_W-1:0] u);
            case (u)
                UNIT_MHZ_MILLI: return CLK_HZ * 250;
                UNIT_HZ:        return CLK_HZ * 250 / 1000;
                UNIT_KHZ:       return CLK_HZ * 250 / 1000000;
                default:        return CLK_HZ * 250 / 1000000000;
            endcase
        endfunction

        function automatic divider_word_t predict_divider(logic [FREQ_W-1:0] fq,
                                                           logic [UNIT_W-1:0] u);
            divider_word_t w;
            longint unsigned base, saved, dv, scale, num, act;
            bit halved;
            base = unit_base(u);
            halved = base > 64'h7FFFFFFF;
            saved = halved ? base : base * 2;
            w.code = PRE_DIV1;
            w.high = 1'b0;
            scale = 1;
            // zero frequency means the largest divider
            if (fq == 0) dv = 64'hFFFFFFFF;
            else dv = (base * 131072) / fq;
            // request above the maximum rate
            if (dv == 0) begin
                w.high = 1'b1;
                dv = 1;
            end
            if (dv > DIV_LIMIT) begin
                dv = dv >> 3; w.code = PRE_DIV8; scale = 8;
                if (dv > DIV_LIMIT) begin
                    dv = dv >> 3; w.code = PRE_DIV64; scale = 64;
                    if (dv > DIV_LIMIT) begin
                        dv = dv >> 2; w.code = PRE_DIV256; scale = 256;
                        if (dv > DIV_LIMIT) begin
                            dv = dv >> 2; w.code = PRE_DIV1024; scale = 1024;
                            if (dv > DIV_LIMIT) dv = DIV_LIMIT;
                        end
                    end
                end
            end
            num = saved * 65536 * (halved ? 2 : 1);
            act = num / (dv * scale);
            if (act > ACTUAL_MAX) act = ACTUAL_MAX;
            w.cmp = CMP_W'(dv - 1);
            w.actual = FREQ_W'(act);
            return w;
        endfunction

        function void note_request(logic [FREQ_W-1:0] fq, logic [UNIT_W-1:0] u);
            pending.push_back(predict_divider(fq, u));
        endfunction

        function void check_response(divider_word_t got);
            divider_word_t exp_w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response word %h", got);
                return;
            end
            exp_w = pending.pop_front();
            checked++;
            code_seen[got.code]++;
            if (got.high) too_high_seen++;
            if (got.code !== exp_w.code || got.cmp !== exp_w.cmp ||
                got.high !== exp_w.high || got.actual !== exp_w.actual) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: expected code %0d cmp %h high %b actual %h, got code %0d cmp %h high %b actual %h",
                             checked, exp_w.code, exp_w.cmp, exp_w.high, exp_w.actual,
                             got.code, got.cmp, got.high, got.actual);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ftd_req_if req_ch();
    ftd_rsp_if rsp_ch();

    frequency_to_timer_divider_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    divider_scoreboard sb = new();

    // idling percentages for the current phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    always #10 clk = ~clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.freq_value = '0;
        req_ch.unit_index = '0;
        rsp_ch.ready = 1'b0;
    end

    // response side: check on handshake, then decide the next ready
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response({rsp_ch.prescaler_code, rsp_ch.compare_value,
                               rsp_ch.too_high, rsp_ch.actual_freq});
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // present one word and hold it until accepted, with an optional gap after
    task automatic send_word(logic [FREQ_W-1:0] fq, logic [UNIT_W-1:0] u);
        req_ch.valid <= 1'b1;
        req_ch.freq_value <= fq;
        req_ch.unit_index <= u;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(fq, u);
        items_sent++;
        // each idle cycle is drawn on its own
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_pipeline();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // random request, biased towards divider boundaries and short values
    task automatic send_random();
        logic [FREQ_W-1:0] fq;
        logic [UNIT_W-1:0] u;
        longint unsigned t, b;
        int sel;
        u = UNIT_W'($urandom());
        sel = $urandom_range(9);
        if (sel < 3) begin
            fq = FREQ_W'($urandom());
        end else if (sel < 6) begin
            fq = FREQ_W'($urandom()) >> $urandom_range(FREQ_W - 1);
        end else begin
            // land near a prescaler threshold
            case ($urandom_range(4))
                0: t = 64'h10000;
                1: t = 64'h80000;
                2: t = 64'h400000;
                3: t = 64'h1000000;
                default: t = 64'h4000000;
            endcase
            b = sb.unit_base(u) * 131072 / t;
            b = b + $urandom_range(4) - 2;
            fq = (b > ACTUAL_MAX) ? FREQ_W'($urandom()) : FREQ_W'(b);
        end
        send_word(fq, u);
    endtask

    initial begin
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, smallest, largest and 1.0 (Q14.16) for each unit
        for (int u = 0; u < 4; u++) begin
            send_word('0, UNIT_W'(u));
            send_word(FREQ_W'(1), UNIT_W'(u));
            send_word(ACTUAL_MAX, UNIT_W'(u));
            send_word(FREQ_W'(32'h10000), UNIT_W'(u));
        end
        send_word(FREQ_W'(32'h2AAAAAAA), UNIT_HZ);
        send_word(FREQ_W'(32'h15555555), UNIT_KHZ);
        send_word(FREQ_W'(32'h00080000), UNIT_MHZ);
        send_word(FREQ_W'(32'h00000003), UNIT_MHZ_MILLI);

        // sender holds off until every response is back
        drain_pipeline();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            n = 0;
            while (n < 308) begin
                send_random();
                n++;
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_pipeline();
        repeat (2 * LATENCY) @(posedge clk);

        $display("sent %0d request words, checked %0d responses, %0d too high",
                 items_sent, sb.checked, sb.too_high_seen);
        $display("prescaler codes seen: div1 %0d div8 %0d div64 %0d div256 %0d div1024 %0d",
                 sb.code_seen[1], sb.code_seen[2], sb.code_seen[3],
                 sb.code_seen[4], sb.code_seen[5]);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
